>>> design/atan2_integer_degrees_defines.svh
// ----------------------------------------------------------------------------
// atan2_integer_degrees assertion macros
// shared property forms used by the files that carry assertions
// ----------------------------------------------------------------------------
`ifndef ATAN2_INTEGER_DEGREES_DEFINES_SVH
`define ATAN2_INTEGER_DEGREES_DEFINES_SVH

// same-cycle implication, checked outside reset
`define A2D_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define A2D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/a2d_pkg.sv
// ----------------------------------------------------------------------------
// a2d_pkg
// types, constants and the tangent threshold table for the atan2 block
// ----------------------------------------------------------------------------
package a2d_pkg;

    // field widths
    localparam int COORD_W     = 11;
    localparam int ANGLE_W     = 9;
    localparam int COORD_LIMIT = 1024;
    localparam int MAG_W       = $clog2(COORD_LIMIT);
    localparam int FRAC_BITS   = 24;
    localparam int THR_W       = 30;
    localparam int THR_N       = 90;
    localparam int IDX_W       = 7;
    localparam int STEPS       = IDX_W;
    localparam int CMP_W       = MAG_W + FRAC_BITS;
    localparam int PROD_W      = MAG_W + THR_W;

    localparam logic [MAG_W-1:0]   MAG_MAX  = MAG_W'(COORD_LIMIT - 1);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(THR_N - 1);

    // output angle constants
    localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
    localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
    localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
    localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

    // fixed point constants for the table build (Q60)
    localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60  = 64'h1000000000000000;
    localparam logic [63:0] STEP_Q60 = PI_Q60 / 64'd180;

    // classified input transaction
    typedef struct packed {
        logic             x_zero;
        logic             x_neg;
        logic             y_neg;
        logic             y_pos;
        logic [MAG_W-1:0] mag_a;
        logic [MAG_W-1:0] mag_b;
    } item_t;

    typedef logic [THR_W-1:0] thr_arr_t [0:THR_N-1];

    // floor(a*b / 2^60)
    function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[123:60];
    endfunction

    // shift-subtract divide, returns {quotient, remainder}
    function automatic logic [127:0] udivmod64(input logic [63:0] num,
                                              input logic [63:0] den);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], num[i]};
            if (r >= {1'b0, den}) begin
                r    = r - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    // tan(k deg) * 2^24, rounded half up, from sin and cos series
    function automatic thr_arr_t build_thresh();
        thr_arr_t     tbl;
        logic [63:0]  x, x2, term, pos, neg, s, c, q, r;
        logic [127:0] dm;
        logic         minus;
        tbl[0] = '0;
        for (int k = 1; k < THR_N; k++) begin
            x  = STEP_Q60 * 64'(k);
            x2 = mul60(x, x);

            // sine series
            term  = x;
            pos   = x;
            neg   = '0;
            minus = 1'b1;
            for (int n = 3; n <= 41; n += 2) begin
                dm   = udivmod64(mul60(term, x2), 64'((n - 1) * n));
                term = dm[127:64];
                if (minus)
                    neg = neg + term;
                else
                    pos = pos + term;
                minus = !minus;
            end
            s = pos - neg;

            // cosine series
            term  = ONE_Q60;
            pos   = term;
            neg   = '0;
            minus = 1'b1;
            for (int n = 2; n <= 40; n += 2) begin
                dm   = udivmod64(mul60(term, x2), 64'((n - 1) * n));
                term = dm[127:64];
                if (minus)
                    neg = neg + term;
                else
                    pos = pos + term;
                minus = !minus;
            end
            c = pos - neg;
            if (c == 64'd0)
                c = 64'd1;

            // quotient with one extra fraction bit, then round
            dm = udivmod64(s, c);
            q  = dm[127:64];
            r  = dm[63:0];
            for (int n = 0; n < FRAC_BITS + 1; n++) begin
                r = r << 1;
                q = q << 1;
                if (r >= c) begin
                    r    = r - c;
                    q[0] = 1'b1;
                end
            end
            tbl[k] = THR_W'((q + 64'd1) >> 1);
        end
        return tbl;
    endfunction

    localparam thr_arr_t THRESH = build_thresh();

endpackage

>>> design/a2d_front.sv
// ----------------------------------------------------------------------------
// a2d_front
// classifies an incoming vector: signs, zero test, saturated magnitudes
// ----------------------------------------------------------------------------
module a2d_front
    import a2d_pkg::*;
(
    input  logic [COORD_W-1:0] vec_x,
    input  logic [COORD_W-1:0] vec_y,
    output item_t              item
);

    logic [COORD_W-1:0] abs_x;
    logic [COORD_W-1:0] abs_y;

    // two's complement magnitudes, the most negative code maps to 2^10
    assign abs_x = vec_x[COORD_W-1] ? (~vec_x + COORD_W'(1)) : vec_x;
    assign abs_y = vec_y[COORD_W-1] ? (~vec_y + COORD_W'(1)) : vec_y;

    // quadrant flags and saturation
    always_comb
    begin
        item.x_zero = (vec_x == '0);
        item.x_neg  = vec_x[COORD_W-1];
        item.y_neg  = vec_y[COORD_W-1];
        item.y_pos  = !vec_y[COORD_W-1] && (vec_y != '0);
        item.mag_a  = (abs_y > COORD_W'(MAG_MAX)) ? MAG_MAX : abs_y[MAG_W-1:0];
        item.mag_b  = (abs_x > COORD_W'(MAG_MAX)) ? MAG_MAX : abs_x[MAG_W-1:0];
    end

endmodule

>>> design/a2d_fifo.sv
// ----------------------------------------------------------------------------
// a2d_fifo
// small register queue with fall-through read data and a fill count
// ----------------------------------------------------------------------------
module a2d_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

>>> design/a2d_back.sv
// ----------------------------------------------------------------------------
// a2d_back
// pipelined binary search for the truncated angle and quadrant mapping
// ----------------------------------------------------------------------------
module a2d_back
    import a2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  item_t              in_item,
    output logic               res_valid,
    output logic [ANGLE_W-1:0] res_angle
);

    typedef struct packed {
        item_t            item;
        logic [IDX_W-1:0] t;
    } srch_t;

    typedef struct packed {
        srch_t             srch;
        logic [IDX_W-1:0]  cand;
        logic              over;
        logic [PROD_W-1:0] prod;
    } mul_t;

    srch_t              cmp_reg       [0:STEPS];
    logic               cmp_valid_reg [0:STEPS];
    mul_t               mul_reg       [0:STEPS-1];
    logic               mul_valid_reg [0:STEPS-1];
    logic               res_valid_reg;
    logic [ANGLE_W-1:0] res_angle_reg, res_angle_next;

    // search entry, t starts at zero since tan(0) always passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmp_valid_reg[0] <= 1'b0;
        else
            cmp_valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        cmp_reg[0].item <= in_item;
        cmp_reg[0].t    <= '0;
    end

    // one result bit per step: a multiply stage, then a compare stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam int BIT = STEPS - 1 - i;

        logic [IDX_W-1:0]  cand;
        logic              over;
        logic [IDX_W-1:0]  tbl_idx;
        logic [PROD_W-1:0] prod;
        logic [PROD_W-1:0] lhs;
        logic              hit;

        // candidate index and b * tan threshold
        assign cand    = cmp_reg[i].t | (IDX_W'(1) << BIT);
        assign over    = (cand > IDX_LAST);
        assign tbl_idx = over ? '0 : cand;
        assign prod    = PROD_W'(cmp_reg[i].item.mag_b) * PROD_W'(THRESH[tbl_idx]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                mul_valid_reg[i] <= 1'b0;
            else
                mul_valid_reg[i] <= cmp_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            mul_reg[i].srch <= cmp_reg[i];
            mul_reg[i].cand <= cand;
            mul_reg[i].over <= over;
            mul_reg[i].prod <= prod;
        end

        // a * 2^24 against the product
        assign lhs = PROD_W'({mul_reg[i].srch.item.mag_a, {FRAC_BITS{1'b0}}});
        assign hit = !mul_reg[i].over && (lhs >= mul_reg[i].prod);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cmp_valid_reg[i+1] <= 1'b0;
            else
                cmp_valid_reg[i+1] <= mul_valid_reg[i];
        end

        always_ff @(posedge clk)
        begin
            cmp_reg[i+1].item <= mul_reg[i].srch.item;
            cmp_reg[i+1].t    <= hit ? mul_reg[i].cand : mul_reg[i].srch.t;
        end
    end

    // quadrant mapping
    always_comb
    begin
        logic [ANGLE_W-1:0] t_ext;
        t_ext = ANGLE_W'(cmp_reg[STEPS].t);
        if (cmp_reg[STEPS].item.x_zero)
            res_angle_next = cmp_reg[STEPS].item.y_pos ? DEG_90 : DEG_270;
        else if (!cmp_reg[STEPS].item.x_neg)
            res_angle_next = cmp_reg[STEPS].item.y_neg ? (DEG_360 - t_ext) : t_ext;
        else
            res_angle_next = cmp_reg[STEPS].item.y_neg ? (DEG_180 + t_ext)
                                                       : (DEG_180 - t_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= cmp_valid_reg[STEPS];
    end

    always_ff @(posedge clk)
    begin
        res_angle_reg <= res_angle_next;
    end

    assign res_valid = res_valid_reg;
    assign res_angle = res_angle_reg;

endmodule

>>> design/atan2_integer_degrees.sv
// ----------------------------------------------------------------------------
// atan2_integer_degrees
// direction of a signed vector in whole degrees, 0 to 360
// ----------------------------------------------------------------------------
// Usage:
// - input channel: drive vec_x/vec_y and raise push; the transaction is taken
//   at a rising edge with push high and full low
// - result channel: angle_deg is valid while empty is low; raise pop to take
//   it, the transaction completes at an edge with pop high and empty low
// - one transaction per cycle sustained on both sides while pop keeps up
// - path from the accepting edge to empty going low: the input queue, the
//   angle search (seven steps, one multiply and one compare stage each),
//   the quadrant map register and the result queue
// - results come out in input order
// - when the receiver stalls, results collect in the result queue; new work
//   enters the search only while the queue has a free slot for it, after
//   which the input queue fills and full rises
// - reset clears both queues and the search pipeline; the block is ready as
//   soon as reset is released
// ----------------------------------------------------------------------------
`include "atan2_integer_degrees_defines.svh"

module atan2_integer_degrees
    import a2d_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [COORD_W-1:0] vec_x,
    input  logic [COORD_W-1:0] vec_y,
    output logic               empty,
    input  logic               pop,
    output logic [ANGLE_W-1:0] angle_deg
);

    localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    item_t                 front_item;
    item_t                 mid_item;
    logic                  mid_empty;
    logic [MID_CNT_W-1:0]  mid_count;
    logic                  issue;
    logic                  back_valid;
    logic [ANGLE_W-1:0]    back_angle;
    logic                  out_full;
    logic [OUT_CNT_W-1:0]  out_count;
    logic                  out_taken;
    logic [OUT_CNT_W-1:0]  inflight_reg, inflight_next;

    // front: classify the incoming vector
    a2d_front u_front (
        .vec_x (vec_x),
        .vec_y (vec_y),
        .item  (front_item)
    );

    // queue between front and back
    a2d_fifo #(
        .WIDTH ($bits(item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (issue),
        .rdata (mid_item),
        .empty (mid_empty),
        .count (mid_count)
    );

    // issue only with a result slot reserved
    assign issue     = !mid_empty && (inflight_reg < OUT_CNT_W'(OUT_DEPTH));
    assign out_taken = pop && !empty;

    always_comb
    begin
        inflight_next = inflight_reg + OUT_CNT_W'(issue) - OUT_CNT_W'(out_taken);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // back: angle search and quadrant map
    a2d_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue),
        .in_item   (mid_item),
        .res_valid (back_valid),
        .res_angle (back_angle)
    );

    // result queue
    a2d_fifo #(
        .WIDTH (ANGLE_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_valid),
        .wdata (back_angle),
        .full  (out_full),
        .pop   (pop),
        .rdata (angle_deg),
        .empty (empty),
        .count (out_count)
    );

    // checks
    `A2D_ASSERT_IMPLY(a_no_result_drop, back_valid, !out_full,
                      "result arrived at a full result queue")
    `A2D_ASSERT_IMPLY(a_credit_bound, 1'b1,
                      (inflight_reg <= OUT_CNT_W'(OUT_DEPTH)) && (out_count <= inflight_reg),
                      "in-flight count out of bounds")
    `A2D_ASSERT_NEXT(a_issue_counted, issue && !out_taken, inflight_reg != '0,
                     "issued transaction not counted")
    `A2D_ASSERT_IMPLY(a_angle_range, !empty, angle_deg <= DEG_360,
                      "angle above 360 degrees")
    `A2D_ASSERT_IMPLY(a_mid_count, !mid_empty, mid_count != '0,
                      "input queue empty flag disagrees with count")

endmodule
